// ===== hw/rtl/bloom_filter_insert_query_unit_defines.svh =====
// Assertion helpers for the bloom filter unit.
// Both macros sample on the rising edge of clk_i and are quiet in reset.
`ifndef BLOOM_FILTER_INSERT_QUERY_UNIT_DEFINES_SVH
`define BLOOM_FILTER_INSERT_QUERY_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BFIQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BFIQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bfiq_pkg.sv =====
`default_nettype none

package bfiq_pkg;

  // Request codes carried by req_type
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Probe count after reset
  localparam logic [4:0] NUM_HASHES_RST = 5'd7;

  // Hash mixing rounds and remainder digits (8 bits each)
  localparam int unsigned MIX_ROUNDS = 7;
  localparam int unsigned MOD_DIGITS = 8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_PROBE,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  // One mixing round per cycle
  typedef enum logic [2:0] {
    MIX_ADD21,
    MIX_XOR24,
    MIX_ADD38,
    MIX_XOR14,
    MIX_ADD24,
    MIX_XOR28,
    MIX_ADD31
  } mix_op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    clear;
    logic    load;
    logic    mix;
    mix_op_e mix_op;
    logic    mod_step;
    logic    probe;
    logic    load_out;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bfiq_ctrl.sv =====
`default_nettype none

module bfiq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             cfg_valid_i,
  input  wire logic [4:0]       cfg_data_i,
  input  wire bfiq_pkg::status_t status_i,
  output bfiq_pkg::cmd_t        cmd_o
);

  bfiq_pkg::state_e state_q, state_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [4:0]       probe_cnt_q, probe_cnt_d;
  logic [4:0]       num_hashes_q;

  // Hold state, counters and the probe count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bfiq_pkg::ST_CLEAR;
      cnt_q        <= '0;
      probe_cnt_q  <= '0;
      num_hashes_q <= bfiq_pkg::NUM_HASHES_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      probe_cnt_q <= probe_cnt_d;
      if (cfg_valid_i) begin
        num_hashes_q <= cfg_data_i;
      end
    end
  end

  // Clear the store after reset, then sequence each item: hash, reduce, probe, report a query's result
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    probe_cnt_d  = probe_cnt_q;
    in_stall_o   = 1'b1;
    cmd_o        = '0;
    cmd_o.mix_op = bfiq_pkg::mix_op_e'(cnt_q);

    unique case (state_q)
      bfiq_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = bfiq_pkg::ST_IDLE;
        end
      end
      bfiq_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = bfiq_pkg::ST_HASH;
        end
      end
      bfiq_pkg::ST_HASH: begin
        cmd_o.mix = 1'b1;
        cnt_d     = cnt_q + 3'd1;
        if (cnt_q == 3'(bfiq_pkg::MIX_ROUNDS - 1)) begin
          cnt_d   = '0;
          state_d = bfiq_pkg::ST_MOD;
        end
      end
      bfiq_pkg::ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        cnt_d          = cnt_q + 3'd1;
        if (cnt_q == 3'(bfiq_pkg::MOD_DIGITS - 1)) begin
          probe_cnt_d = '0;
          if (num_hashes_q != 5'd0) begin
            state_d = bfiq_pkg::ST_PROBE;
          end else if (status_i.is_query) begin
            state_d = bfiq_pkg::ST_RESULT;
          end else begin
            state_d = bfiq_pkg::ST_IDLE;
          end
        end
      end
      bfiq_pkg::ST_PROBE: begin
        cmd_o.probe = 1'b1;
        probe_cnt_d = probe_cnt_q + 5'd1;
        if (probe_cnt_q == num_hashes_q - 5'd1) begin
          state_d = status_i.is_query ? bfiq_pkg::ST_DRAIN : bfiq_pkg::ST_IDLE;
        end
      end
      bfiq_pkg::ST_DRAIN: begin
        // last read lands in the hit flag
        state_d = bfiq_pkg::ST_RESULT;
      end
      bfiq_pkg::ST_RESULT: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = bfiq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bfiq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bfiq_dp.sv =====
`default_nettype none

module bfiq_dp #(
  parameter int unsigned BIT_COUNT = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bfiq_pkg::cmd_t     cmd_i,
  output bfiq_pkg::status_t       status_o,
  input  wire logic               req_type_i,
  input  wire logic signed [63:0] key_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    found_o
);

  localparam int unsigned AW = $clog2(BIT_COUNT);
  localparam logic [AW:0] NMOD = (AW + 1)'(BIT_COUNT);

  logic              bits_q [BIT_COUNT];
  logic [AW-1:0]     clr_addr_q;
  logic              req_q;
  logic [63:0]       hash_q, hash_d;
  logic signed [63:0] hash_s;
  logic [63:0]       sar14, sar24, sar28;
  logic [AW-1:0]     rem_q, rem_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW:0]       acc;
  logic [AW:0]       sum;
  logic              rd_q;
  logic              rd_vld_q;
  logic              hit_q;
  logic              out_valid_q;
  logic              found_q;

  assign hash_s = hash_q;

  // Mix the key, one round per cycle
  always_comb begin
    sar14  = hash_s >>> 14;
    sar24  = hash_s >>> 24;
    sar28  = hash_s >>> 28;
    hash_d = hash_q;
    unique case (cmd_i.mix_op)
      bfiq_pkg::MIX_ADD21: hash_d = ~hash_q + (hash_q << 21);
      bfiq_pkg::MIX_XOR24: hash_d = hash_q ^ sar24;
      bfiq_pkg::MIX_ADD38: hash_d = hash_q + (hash_q << 3) + (hash_q << 8);
      bfiq_pkg::MIX_XOR14: hash_d = hash_q ^ sar14;
      bfiq_pkg::MIX_ADD24: hash_d = hash_q + (hash_q << 2) + (hash_q << 4);
      bfiq_pkg::MIX_XOR28: hash_d = hash_q ^ sar28;
      bfiq_pkg::MIX_ADD31: hash_d = hash_q + (hash_q << 31);
      default:             hash_d = hash_q;
    endcase
  end

  // Fold the top byte of the hash into the remainder, one bit a step
  always_comb begin
    acc = {1'b0, rem_q};
    for (int j = 7; j >= 0; j--) begin
      acc = {acc[AW-1:0], hash_q[56 + j]};
      if (acc >= NMOD) begin
        acc = acc - NMOD;
      end
    end
    rem_d = acc[AW-1:0];
  end

  // Advance the probe position by the remainder, wrapping at the store size
  always_comb begin
    sum = {1'b0, pos_q} + {1'b0, rem_q};
    if (sum >= NMOD) begin
      sum = sum - NMOD;
    end
    pos_d = sum[AW-1:0];
  end

  // Hold the item and its hash state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      hash_q <= key_i;
      rem_q  <= '0;
      hit_q  <= 1'b1;
    end else begin
      if (cmd_i.mix) begin
        hash_q <= hash_d;
      end
      if (cmd_i.mod_step) begin
        hash_q <= hash_q << 8;
        rem_q  <= rem_d;
        pos_q  <= rem_d;
      end
      if (cmd_i.probe) begin
        pos_q <= pos_d;
      end
      if (rd_vld_q && !rd_q) begin
        hit_q <= 1'b0;
      end
    end
    if (cmd_i.load_out) begin
      found_q <= hit_q;
    end
  end

  // Bit store: clear pass, probe writes, registered probe reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      bits_q[clr_addr_q] <= 1'b0;
    end else if (cmd_i.probe && req_q == bfiq_pkg::REQ_INSERT) begin
      bits_q[pos_q] <= 1'b1;
    end
    rd_q <= bits_q[pos_q];
  end

  // Control flops: clear address, read valid, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      rd_vld_q <= cmd_i.probe && (req_q == bfiq_pkg::REQ_QUERY);
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.clr_last = (clr_addr_q == AW'(BIT_COUNT - 1));
  assign status_o.is_query = (req_q == bfiq_pkg::REQ_QUERY);
  assign status_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bloom_filter_insert_query_unit.sv =====
// Sequence: accept, 7 hash rounds, the remainder reduction one hash byte per step, then
// num_hashes probes at one probe per cycle; a query then loads its result, waiting while
// the output is stalled. The input stays stalled until the previous item is done, with
// probes paced by the single bit-store port.
// Reset: clears the probe count to 7 and runs a clearing pass over every one of the BIT_COUNT
// bits (4096 by default) of the bit store; no item is accepted during it.
`default_nettype none

`include "bloom_filter_insert_query_unit_defines.svh"

module bloom_filter_insert_query_unit #(
  parameter int unsigned BIT_COUNT = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               req_type_i,
  input  wire logic signed [63:0] key_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    found_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [4:0]         cfg_data_i
);

  bfiq_pkg::cmd_t    cmd;
  bfiq_pkg::status_t status;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  bfiq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bfiq_dp #(
    .BIT_COUNT (BIT_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o)
  );

  // A result never overwrites one that is still waiting
  `BFIQ_ASSERT_SAME(a_no_overwrite, cmd.load_out, !(out_valid_o && out_stall_i), "result lost")
  // No item is taken while the store is being cleared
  `BFIQ_ASSERT_SAME(a_clear_blocks_input, cmd.clear, in_stall_o, "item taken during clear")
  // An accepted item keeps the input closed for the next cycle
  `BFIQ_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input open while busy")

endmodule

`default_nettype wire

// ===== bench/tb_bloom_filter_insert_query_unit.sv =====
module tb_bloom_filter_insert_query_unit;

  localparam int unsigned BIT_COUNT      = 4096;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned PHASE_ITEMS    = 62;

  typedef struct packed {
    logic        req;
    logic [63:0] key;
  } bloom_req_t;

  logic        clk_i;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        req_type   = bfiq_pkg::REQ_INSERT;
  logic [63:0] key        = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic        found;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data   = '0;

  // Model state: bit store, probe count, expected answers
  logic        filter_cells [BIT_COUNT];
  logic [4:0]  probe_count = bfiq_pkg::NUM_HASHES_RST;
  logic        found_expected [$];
  bloom_req_t  pending_items [$];
  logic [63:0] known_keys [$];

  // Sender and receiver pacing
  bit          idle_on       = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned run_left      = 0;
  bit          stall_phase   = 1'b0;
  int unsigned burst_left    = 1;
  int unsigned gap_left      = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;

  logic        send_fire;
  logic        nxt_valid;
  logic        nxt_req;
  logic [63:0] nxt_key;
  logic        nxt_stall;
  bloom_req_t  next_item;
  logic        want_found;

  bloom_filter_insert_query_unit #(
    .BIT_COUNT(BIT_COUNT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .req_type_i (req_type),
    .key_i      (key),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .found_o    (found),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] shift_right_arith(input logic [63:0] x, input int unsigned n);
    logic signed [63:0] s;
    s = x;
    s = s >>> n;
    return s;
  endfunction

  // Shift-add-xor key mix, 64-bit wrapping
  function automatic logic [63:0] mix_key64(input logic [63:0] k);
    logic [63:0] x;
    x = ~k + (k << 21);
    x = x ^ shift_right_arith(x, 24);
    x = (x + (x << 3)) + (x << 8);
    x = x ^ shift_right_arith(x, 14);
    x = (x + (x << 2)) + (x << 4);
    x = x ^ shift_right_arith(x, 28);
    x = x + (x << 31);
    return x;
  endfunction

  // Walk the probes of one key: set cells on insert, test them on query
  function automatic void apply_to_filter(input logic req, input logic [63:0] k);
    logic [63:0] h1;
    logic [63:0] probe_pos;
    logic        hit;
    int unsigned i;
    h1  = mix_key64(k) % 64'(BIT_COUNT);
    hit = 1'b1;
    for (i = 0; i < probe_count; i++) begin
      probe_pos = (h1 + 64'(i) * h1) % 64'(BIT_COUNT);
      if (req == bfiq_pkg::REQ_INSERT) filter_cells[probe_pos] = 1'b1;
      else if (!filter_cells[probe_pos]) hit = 1'b0;
    end
    if (req == bfiq_pkg::REQ_QUERY) found_expected.push_back(hit);
  endfunction

  function automatic logic [63:0] fresh_key();
    case ($urandom_range(0, 7))
      0: return 64'($urandom_range(0, 255));
      1: return -64'($urandom_range(1, 256));
      2: begin
        case ($urandom_range(0, 3))
          0: return 64'h8000_0000_0000_0000;
          1: return 64'h7FFF_FFFF_FFFF_FFFF;
          2: return 64'd0;
          default: return '1;
        endcase
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_item(input logic req, input logic [63:0] k);
    pending_items.push_back('{req: req, key: k});
    if (req == bfiq_pkg::REQ_INSERT) known_keys.push_back(k);
  endtask

  // Mostly insert-then-query sequences, some absent keys and repeat inserts
  task automatic queue_random_items(input int unsigned count);
    int unsigned n;
    int unsigned pick;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40 || known_keys.size() == 0)
        queue_item(bfiq_pkg::REQ_INSERT, fresh_key());
      else if (pick < 80)
        queue_item(bfiq_pkg::REQ_QUERY, known_keys[$urandom_range(0, known_keys.size() - 1)]);
      else if (pick < 90)
        queue_item(bfiq_pkg::REQ_QUERY, fresh_key());
      else
        queue_item(bfiq_pkg::REQ_INSERT, known_keys[$urandom_range(0, known_keys.size() - 1)]);
    end
  endtask

  // Hold until the sender is empty, the block is idle and every answer has arrived
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid || in_stall || found_expected.size() != 0);
  endtask

  task automatic write_probe_count(input logic [4:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid   <= 1'b0;
    probe_count  = value;
  endtask

  // Driver: offer items in bursts, predict each accepted one
  always @(posedge clk_i) begin
    if (rst_n) begin
      send_fire = in_valid && !in_stall;
      nxt_valid = in_valid;
      nxt_req   = req_type;
      nxt_key   = key;
      if (send_fire) begin
        apply_to_filter(req_type, key);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = idle_on ? $urandom_range(0, 6) : 0;
        end
      end
      if (!in_valid || send_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          nxt_valid = 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          nxt_valid = 1'b1;
          nxt_req   = next_item.req;
          nxt_key   = next_item.key;
        end else begin
          nxt_valid = 1'b0;
        end
      end
      in_valid <= nxt_valid;
      req_type <= nxt_req;
      key      <= nxt_key;
    end
  end

  // Receiver: long hold on request, no stalls while idle_on is clear, else alternating stall runs
  always @(posedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else if (!idle_on) begin
      nxt_stall = 1'b0;
    end else begin
      if (run_left == 0) begin
        stall_phase = ~stall_phase;
        run_left    = stall_phase ? $urandom_range(1, 5) : $urandom_range(1, 10);
      end
      run_left--;
      nxt_stall = stall_phase;
    end
    out_stall <= nxt_stall;
  end

  // Monitor: compare each accepted answer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) begin
      if (found_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: found %0b", found);
      end else begin
        want_found = found_expected.pop_front();
        if (found !== want_found) begin
          mismatches++;
          if (mismatches <= 10)
            $display("found mismatch: expected %0b, got %0b", want_found, found);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned c;
    logic [4:0]  cfg_plan [1:7];
    for (c = 0; c < BIT_COUNT; c++) filter_cells[c] = 1'b0;
    cfg_plan[1] = 5'd0;
    cfg_plan[2] = 5'd31;
    cfg_plan[3] = 5'd1;
    cfg_plan[4] = 5'd16;
    cfg_plan[5] = 5'd17;
    cfg_plan[6] = 5'($urandom_range(2, 30));
    cfg_plan[7] = 5'd5;

    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed items at the reset probe count
    queue_item(bfiq_pkg::REQ_QUERY,  64'd0);
    queue_item(bfiq_pkg::REQ_INSERT, 64'd0);
    queue_item(bfiq_pkg::REQ_QUERY,  64'd0);
    queue_item(bfiq_pkg::REQ_INSERT, 64'h8000_0000_0000_0000);
    queue_item(bfiq_pkg::REQ_QUERY,  64'h8000_0000_0000_0000);
    queue_item(bfiq_pkg::REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
    queue_item(bfiq_pkg::REQ_QUERY,  64'h7FFF_FFFF_FFFF_FFFF);
    queue_item(bfiq_pkg::REQ_QUERY,  '1);
    queue_item(bfiq_pkg::REQ_INSERT, '1);
    queue_item(bfiq_pkg::REQ_QUERY,  '1);
    queue_item(bfiq_pkg::REQ_INSERT, 64'd1);
    queue_item(bfiq_pkg::REQ_QUERY,  64'd1);
    queue_item(bfiq_pkg::REQ_QUERY,  64'd2);
    queue_item(bfiq_pkg::REQ_QUERY,  64'h0123_4567_89AB_CDEF);
    queue_item(bfiq_pkg::REQ_INSERT, 64'h0123_4567_89AB_CDEF);
    queue_item(bfiq_pkg::REQ_QUERY,  64'h0123_4567_89AB_CDEF);

    // Random phases, one probe count each
    for (p = 1; p <= 7; p++) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      write_probe_count(cfg_plan[p]);
      idle_on = (p != 4);
      if (p == 1) begin
        queue_item(bfiq_pkg::REQ_INSERT, 64'h5555_AAAA_5555_AAAA);
        queue_item(bfiq_pkg::REQ_QUERY,  64'h5555_AAAA_5555_AAAA);
        queue_item(bfiq_pkg::REQ_QUERY,  64'hDEAD_BEEF_0BAD_F00D);
      end
      if (p == 5) begin
        queue_random_items(PHASE_ITEMS / 2);
        wait_drained();
        queue_random_items(PHASE_ITEMS / 2);
      end else begin
        queue_random_items(PHASE_ITEMS);
      end
      if (p == 2) hold_requests++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && found_expected.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
